// ----- rtl/ilir_pkg.sv -----
// Shared types and constants for the indexed list block.
// No dependencies; imported by every module of the block.
package ilir_pkg;

   localparam int DEPTH      = 64;
   localparam int ELEM_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int POS_W      = 7;
   localparam int LIM_W      = 7;
   localparam int DATA_W     = 32;
   localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam logic [LIM_W-1:0] LIMIT_RESET = 7'd64;

   typedef enum logic [1:0] {
      CMD_GET    = 2'd0,
      CMD_SET    = 2'd1,
      CMD_INSERT = 2'd2,
      CMD_REMOVE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CK_NONE = 2'd0,
      CK_SET  = 2'd1,
      CK_INS  = 2'd2,
      CK_REM  = 2'd3
   } cell_kind_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      cell_kind_type         kind;
      logic [IDX_W-1:0]      pos;
      logic [ELEM_WIDTH-1:0] value;
   } cell_cmd_type;

   // decode result for the response path
   typedef struct packed {
      logic             ok;
      status_type       status;
      logic [CNT_W-1:0] count_next;
   } dec_type;

endpackage

// ----- rtl/ilir_cell.sv -----
// One storage cell of the list chain: holds one entry, shifts with neighbors.
// Depends on ilir_pkg.
module ilir_cell (
   input  logic                           clock,
   input  ilir_pkg::cell_cmd_type         cmd,
   input  logic [ilir_pkg::IDX_W-1:0]     cell_idx,
   input  logic [ilir_pkg::ELEM_WIDTH-1:0] below_val,
   input  logic [ilir_pkg::ELEM_WIDTH-1:0] above_val,
   output logic [ilir_pkg::ELEM_WIDTH-1:0] value_out,
   output logic [ilir_pkg::ELEM_WIDTH-1:0] read_out
);
   import ilir_pkg::*;

   logic [ELEM_WIDTH-1:0] entry_ff;
   logic [ELEM_WIDTH-1:0] entry_in;
   logic                  sel;
   logic                  past_pos;

   assign sel      = (cell_idx == cmd.pos);
   assign past_pos = (cell_idx > cmd.pos);

   always_comb begin
      entry_in = entry_ff;
      case (cmd.kind)
         CK_SET: begin
            if (sel) entry_in = cmd.value;
         end
         CK_INS: begin
            if (sel) entry_in = cmd.value;
            else if (past_pos) entry_in = below_val;
         end
         CK_REM: begin
            if (sel || past_pos) entry_in = above_val;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign value_out = entry_ff;
   assign read_out  = sel ? entry_ff : '0;

endmodule

// ----- rtl/ilir_ctrl.sv -----
// Request decode, fill count and capacity limit register for the list.
// Depends on ilir_pkg.
module ilir_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [1:0]                      command,
   input  logic [ilir_pkg::POS_W-1:0]      position,
   input  logic [ilir_pkg::ELEM_WIDTH-1:0] value,
   input  logic                            csr_wr_en,
   input  logic [ilir_pkg::LIM_W-1:0]      csr_wr_data,
   output ilir_pkg::cell_cmd_type          cell_cmd,
   output ilir_pkg::dec_type               dec
);
   import ilir_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [LIM_W-1:0] limit_ff, limit_in;
   logic [CMP_W-1:0] cnt_ext, pos_ext, lim_ext, eff_lim;
   cmd_type          cmd;

   assign cmd     = cmd_type'(command);
   assign cnt_ext = CMP_W'(count_ff);
   assign pos_ext = CMP_W'(position);
   assign lim_ext = CMP_W'(limit_ff);
   assign eff_lim = (lim_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : lim_ext;

   always_comb begin
      dec.ok         = 1'b0;
      dec.status     = ST_OK;
      dec.count_next = count_ff;
      if (cmd == CMD_INSERT) begin
         if (cnt_ext >= eff_lim) begin
            dec.status = ST_FULL;
         end else if (pos_ext > cnt_ext) begin
            dec.status = ST_RANGE;
         end else begin
            dec.ok         = 1'b1;
            dec.count_next = count_ff + CNT_W'(1);
         end
      end else if (pos_ext >= cnt_ext) begin
         dec.status = ST_RANGE;
      end else begin
         dec.ok = 1'b1;
         if (cmd == CMD_REMOVE) dec.count_next = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      cell_cmd.pos   = position[IDX_W-1:0];
      cell_cmd.value = value;
      cell_cmd.kind  = CK_NONE;
      if (accept && dec.ok) begin
         case (cmd)
            CMD_SET:    cell_cmd.kind = CK_SET;
            CMD_INSERT: cell_cmd.kind = CK_INS;
            CMD_REMOVE: cell_cmd.kind = CK_REM;
            default:    cell_cmd.kind = CK_NONE;
         endcase
      end
   end

   assign count_in = accept ? dec.count_next : count_ff;
   assign limit_in = csr_wr_en ? csr_wr_data : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         limit_ff <= LIMIT_RESET;
      end else begin
         count_ff <= count_in;
         limit_ff <= limit_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count above depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (accept && dec.ok && cmd == CMD_INSERT) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow count");

   a_err_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && !dec.ok) |=> $stable(count_ff))
      else $error("failed request changed count");

endmodule

// ----- rtl/indexed_list_insert_remove.sv -----
// Top level of the indexed list: cell chain, control and response register.
// Depends on ilir_pkg, ilir_cell, ilir_ctrl.
//
// Usage:
//   Requests enter on start with req_command, req_position and req_value.
//   busy is always low: a request is taken in every cycle.
//   Each request gives one response, shown for exactly one cycle on the
//   rsp_ ports with rsp_strobe high, in the cycle after the request.
//   Throughput 1 request per cycle. The whole list shifts at once: every
//   entry sits in its own cell and an insert or remove updates the cell at
//   the position and all cells past it in the same clock edge. Reads go
//   through a gated OR bus across the cells. csr_wr_en / csr_wr_data write
//   the capacity limit (reset 64); the user must write it only while no
//   request is in flight, which the block itself does not enforce.
//   Reset (synchronous) empties the list and restores the limit; entry
//   contents are not cleared. The receiver cannot stall: a response is
//   taken at the edge ending its strobe cycle.
module indexed_list_insert_remove (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_command,
   input  logic [ilir_pkg::POS_W-1:0] req_position,
   input  logic [31:0]                req_value,
   output logic                       rsp_strobe,
   output logic [31:0]                rsp_data_out,
   output logic [1:0]                 rsp_status,
   output logic [6:0]                 rsp_count,
   output logic                       rsp_empty_res,
   input  logic                       csr_wr_en,
   input  logic [ilir_pkg::LIM_W-1:0] csr_wr_data
);
   import ilir_pkg::*;

   logic                  accept;
   cell_cmd_type          cell_cmd;
   dec_type               dec;
   logic [ELEM_WIDTH-1:0] cell_val [DEPTH];
   logic [ELEM_WIDTH-1:0] cell_rd  [DEPTH];
   logic [ELEM_WIDTH-1:0] read_bus;
   logic                  is_read;

   // response registers
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [DATA_W-1:0]     rsp_data_ff,   rsp_data_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]      rsp_count_ff,  rsp_count_in;
   logic                  rsp_empty_ff,  rsp_empty_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   ilir_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .command     (req_command),
      .position    (req_position),
      .value       (ELEM_WIDTH'(req_value)),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cell_cmd    (cell_cmd),
      .dec         (dec)
   );

   // the chain: cell i takes from i-1 on insert and from i+1 on remove
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ELEM_WIDTH-1:0] below, above;
      if (i == 0) begin : g_lo
         assign below = '0;
      end else begin : g_lo_n
         assign below = cell_val[i-1];
      end
      if (i == DEPTH - 1) begin : g_hi
         assign above = '0;
      end else begin : g_hi_n
         assign above = cell_val[i+1];
      end
      ilir_cell u_cell (
         .clock     (clock),
         .cmd       (cell_cmd),
         .cell_idx  (IDX_W'(i)),
         .below_val (below),
         .above_val (above),
         .value_out (cell_val[i]),
         .read_out  (cell_rd[i])
      );
   end

   // only the addressed cell drives a nonzero word
   always_comb begin
      read_bus = '0;
      for (int k = 0; k < DEPTH; k++) begin
         read_bus = read_bus | cell_rd[k];
      end
   end

   assign is_read       = dec.ok && (cmd_type'(req_command) != CMD_INSERT);
   assign rsp_strobe_in = accept;
   assign rsp_data_in   = is_read ? DATA_W'(read_bus) : '0;
   assign rsp_status_in = dec.status;
   assign rsp_count_in  = dec.count_next;
   assign rsp_empty_in  = (dec.count_next == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_empty_ff  <= rsp_empty_in;
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_data_out  = rsp_data_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_count     = 7'(rsp_count_ff);
   assign rsp_empty_res = rsp_empty_ff;

   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("request without response");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_strobe)
      else $error("response without request");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_empty_res == (rsp_count == 7'd0)))
      else $error("empty flag disagrees with count");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != ST_OK) |-> rsp_data_out == '0)
      else $error("error response carries data");

endmodule
